/* rtl/htw_pkg.sv */
package htw_pkg;

  // Table geometry and count width
  localparam int NODE_BITS  = 9;
  localparam int NODES      = 512;
  localparam int COUNT_BITS = 24;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Up to eight stream bits per data byte
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // Input operation codes
  localparam logic FUNC_NODE_WR = 1'b0;
  localparam logic FUNC_DATA    = 1'b1;

  // Root node index
  localparam logic [NODE_BITS-1:0] ROOT_NODE = '0;

  typedef struct packed {
    logic                 func;
    logic [NODE_BITS-1:0] node_index;
    logic [NODE_BITS-1:0] zero_child;
    logic [NODE_BITS-1:0] one_child;
    logic                 is_leaf;
    logic [7:0]           leaf_symbol;
    logic [7:0]           data_byte;
    logic [3:0]           valid_bits;
    logic                 final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]            symbol;
    logic                  symbol_valid;
    logic                  last;
    logic                  stream_end;
    logic                  partial_code;
    logic [COUNT_BITS-1:0] total_symbols;
  } out_item_t;

  // One table entry
  typedef struct packed {
    logic [NODE_BITS-1:0] zero_child;
    logic [NODE_BITS-1:0] one_child;
    logic                 is_leaf;
    logic [7:0]           leaf_symbol;
  } node_ent_t;

  // Walker to node table
  typedef struct packed {
    logic                 wr_en;
    logic [NODE_BITS-1:0] wr_addr;
    node_ent_t            wr_data;
    logic                 rd_en;
    logic [NODE_BITS-1:0] rd_addr;
  } mem_req_t;

  // Walker to output register
  typedef struct packed {
    logic      push;
    out_item_t item;
  } res_t;

endpackage

/* rtl/htw_node_mem.sv */
module htw_node_mem (
  input  logic                 clk,
  input  htw_pkg::mem_req_t    req,
  output htw_pkg::node_ent_t   rd_data
);

  htw_pkg::node_ent_t mem [htw_pkg::NODES];

  // Single write port, single registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

/* rtl/htw_walker.sv */
module htw_walker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  htw_pkg::in_item_t   in_data,
  output htw_pkg::mem_req_t   mem_req,
  input  htw_pkg::node_ent_t  rd_ent,
  input  logic                slot_free,
  output htw_pkg::res_t       res
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FIRST  = 4'b0010,
    ST_WALK   = 4'b0100,
    ST_FINISH = 4'b1000
  } walk_state_t;

  walk_state_t                        state_r, state_nxt;
  logic [7:0]                         byte_r, byte_nxt;
  logic [3:0]                         nbits_r, nbits_nxt;
  logic                               fin_r, fin_nxt;
  logic [2:0]                         bit_r, bit_nxt;
  logic [htw_pkg::NODE_BITS-1:0]      addr_r, addr_nxt;
  logic [htw_pkg::NODE_BITS-1:0]      cur_r, cur_nxt;
  logic [htw_pkg::COUNT_BITS-1:0]     cnt_r, cnt_nxt;
  logic                               pend_v_r, pend_v_nxt;
  logic [7:0]                         pend_sym_r, pend_sym_nxt;
  logic [htw_pkg::NODE_BITS-1:0]      root_zero_r, root_zero_nxt;
  logic [htw_pkg::NODE_BITS-1:0]      root_one_r, root_one_nxt;

  logic                               accept;
  logic [3:0]                         nbits_in;
  logic                               last_bit;
  logic [2:0]                         sel_pos;
  logic                               sel_bit;
  logic [htw_pkg::NODE_BITS-1:0]      src_zero, src_one, child;
  logic                               walk_go;
  logic                               need_out;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Clamp the bit count to one byte
  assign nbits_in = (in_data.valid_bits > htw_pkg::BYTE_BITS) ? htw_pkg::BYTE_BITS
                                                              : in_data.valid_bits;

  assign last_bit = (({1'b0, bit_r} + 4'd1) == nbits_r);

  // Shared child-select unit: picks the branch for the next stream bit
  always_comb begin
    if (state_r == ST_FIRST) begin
      sel_pos  = bit_r;
      src_zero = rd_ent.zero_child;
      src_one  = rd_ent.one_child;
    end else begin
      sel_pos  = bit_r + 3'd1;
      src_zero = rd_ent.is_leaf ? root_zero_r : rd_ent.zero_child;
      src_one  = rd_ent.is_leaf ? root_one_r  : rd_ent.one_child;
    end
    sel_bit = byte_r[sel_pos];
    child   = sel_bit ? src_one : src_zero;
  end

  // A leaf with a symbol already pending needs the output slot
  assign walk_go  = !(rd_ent.is_leaf && pend_v_r && !slot_free);
  assign need_out = pend_v_r || fin_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    byte_nxt      = byte_r;
    nbits_nxt     = nbits_r;
    fin_nxt       = fin_r;
    bit_nxt       = bit_r;
    addr_nxt      = addr_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_sym_nxt  = pend_sym_r;
    root_zero_nxt = root_zero_r;
    root_one_nxt  = root_one_r;
    mem_req       = '0;
    res           = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.func == htw_pkg::FUNC_NODE_WR) begin
            mem_req.wr_en                = 1'b1;
            mem_req.wr_addr              = in_data.node_index;
            mem_req.wr_data.zero_child   = in_data.zero_child;
            mem_req.wr_data.one_child    = in_data.one_child;
            mem_req.wr_data.is_leaf      = in_data.is_leaf;
            mem_req.wr_data.leaf_symbol  = in_data.leaf_symbol;
            // keep a copy of the root's children for the return after a leaf
            if (in_data.node_index == htw_pkg::ROOT_NODE) begin
              root_zero_nxt = in_data.zero_child;
              root_one_nxt  = in_data.one_child;
            end
          end else begin
            byte_nxt   = in_data.data_byte;
            nbits_nxt  = nbits_in;
            fin_nxt    = in_data.final_byte;
            bit_nxt    = '0;
            pend_v_nxt = 1'b0;
            if (nbits_in == 4'd0) begin
              state_nxt = ST_FINISH;
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = cur_r;
              state_nxt       = ST_FIRST;
            end
          end
        end
      end

      ST_FIRST: begin
        // entry of the current node is here: fetch the child for bit 0
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = child;
        addr_nxt        = child;
        state_nxt       = ST_WALK;
      end

      ST_WALK: begin
        // entry of the node just reached is here
        if (walk_go) begin
          if (rd_ent.is_leaf) begin
            if (pend_v_r) begin
              res.push              = 1'b1;
              res.item.symbol       = pend_sym_r;
              res.item.symbol_valid = 1'b1;
            end
            pend_v_nxt   = 1'b1;
            pend_sym_nxt = rd_ent.leaf_symbol;
            if (cnt_r != htw_pkg::COUNT_MAX) begin
              cnt_nxt = cnt_r + 1'b1;
            end
            cur_nxt = htw_pkg::ROOT_NODE;
          end else begin
            cur_nxt = addr_r;
          end
          if (last_bit) begin
            state_nxt = ST_FINISH;
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = child;
            addr_nxt        = child;
            bit_nxt         = bit_r + 3'd1;
          end
        end
      end

      ST_FINISH: begin
        // last result of the byte, with the end-of-stream report if final
        if (!need_out || slot_free) begin
          if (need_out) begin
            res.push               = 1'b1;
            res.item.symbol        = pend_v_r ? pend_sym_r : 8'd0;
            res.item.symbol_valid  = pend_v_r;
            res.item.last          = 1'b1;
            res.item.stream_end    = fin_r;
            res.item.partial_code  = fin_r && (cur_r != htw_pkg::ROOT_NODE);
            res.item.total_symbols = fin_r ? cnt_r : '0;
          end
          if (fin_r) begin
            cur_nxt = htw_pkg::ROOT_NODE;
            cnt_nxt = '0;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cur_r    <= htw_pkg::ROOT_NODE;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    nbits_r     <= nbits_nxt;
    fin_r       <= fin_nxt;
    bit_r       <= bit_nxt;
    addr_r      <= addr_nxt;
    pend_sym_r  <= pend_sym_nxt;
    root_zero_r <= root_zero_nxt;
    root_one_r  <= root_one_nxt;
  end

endmodule

/* rtl/huffman_tree_walk_decoder.sv */
// Huffman tree-walk decoder. Load the node table with node writes (func 0,
// node 0 is the root), then feed data bytes (func 1), consumed LSB first.
// A data byte with n stream bits (valid_bits clamped to 8) holds the input
// for one table read per bit through the single read port of the node
// table, plus the first read of the current node and a closing step (only
// the closing step when n is 0). Each leaf reached gives one symbol item;
// the last item of a byte has last set, and the final byte closes the
// stream with stream_end, total_symbols and partial_code (trailing bits
// that formed no complete code are dropped). A stall on the output holds
// the walk. Table entries never written read as undefined, so only
// written nodes may be reached.
module huffman_tree_walk_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  htw_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output htw_pkg::out_item_t  out_data
);

  htw_pkg::mem_req_t  mem_req;
  htw_pkg::node_ent_t rd_ent;
  htw_pkg::res_t      res;
  logic               slot_free;
  logic               out_valid_r;
  htw_pkg::out_item_t out_item_r;

  htw_node_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_ent)
  );

  htw_walker u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .mem_req   (mem_req),
    .rd_ent    (rd_ent),
    .slot_free (slot_free),
    .res       (res)
  );

  // Output register: free when empty or being taken this cycle
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.push) begin
      out_item_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Checks
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    res.push |-> slot_free)
    else $error("result pushed into a busy output register");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_end |-> out_data.last)
    else $error("stream end without last");

  a_partial_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.partial_code |-> out_data.stream_end)
    else $error("partial code flagged outside stream end");

  a_report_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.symbol_valid |-> out_data.stream_end && out_data.last)
    else $error("symbol-less item that does not close the stream");

  a_total_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.stream_end |-> out_data.total_symbols == '0)
    else $error("total reported outside stream end");

endmodule
